// ===== src/dct_pkg.sv =====
`default_nettype none
package dct_pkg;
	localparam int ENTRIES = 16;
	localparam int SLOT_W = $clog2(ENTRIES);
	localparam int ENTRY_W = 32 + 32 + 16 + 64 + 64 + 48 + 32 + 32;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_EXPIRE = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	localparam logic CFG_EXPIRE = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	typedef struct packed {
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] hints;
		logic [63:0] name_lo;
		logic [63:0] name_mid;
		logic [47:0] name_hi;
		logic [31:0] last_seen;
		logic [31:0] first_seen;
	} entry_t;

	// string style compare over 22 bytes
	function automatic logic names_equal(input logic [175:0] a, input logic [175:0] b);
		logic eq;
		logic done;
		eq = 1'b1;
		done = 1'b0;
		for (int k = 0; k < 22; k++) begin
			if (!done) begin
				if (a[8*k +: 8] != b[8*k +: 8]) begin
					eq = 1'b0;
					done = 1'b1;
				end else if (a[8*k +: 8] == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		return eq;
	endfunction
endpackage
`default_nettype wire

// ===== src/discovery_cache_table_core.sv =====
// channel | direction | tdata fields (low bit up)                         | tuser
// s_axis  | in        | kind,saddr,daddr,hints,name_lo,name_mid,name_hi,   | -
//         |           | time_req,mask,include_all (307 bits, pad to 312)   |
// m_axis  | out       | out_saddr,out_daddr,out_hints,out_name_lo,mid,hi   | has_entry,status
//         |           | (256 bits)                                         | tlast = last
// cfg     | in        | index (1 bit), data (32 bits)                      | -
// A command makes one table scan through the single RAM read port, one slot per cycle
// on one compare unit while m_axis does not stall the scan.
// Reset clears valid bits and sets config to defaults (expire 600, window 300); table contents need no clear.
// m_axis stall holds the scan; s_axis is not ready until the command ends.
`default_nettype none
module discovery_cache_table_core
	import dct_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [311:0] s_axis_tdata, // kind,saddr,daddr,hints,name_lo,name_mid,name_hi,time_req,mask,include_all
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [255:0] m_axis_tdata, // out_saddr,out_daddr,out_hints,out_name_lo,out_name_mid,out_name_hi
	output logic [1:0] m_axis_tuser, // has_entry,status
	output logic m_axis_tlast,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);
	typedef enum logic [2:0] {IDLE, READ, SCAN, WRITE, DONE} state_t;
	state_t state_q;
	logic [31:0] expire_q, window_q;
	logic [ENTRIES-1:0] valid_q;
	logic [SLOT_W:0] idx_q;
	logic [SLOT_W-1:0] cur_q;
	logic [306:0] cmd_q;
	logic [31:0] first_q;
	logic [SLOT_W-1:0] free_q;
	logic have_free_q;
	logic [4:0] n_q;
	entry_t rd;
	logic [ENTRY_W-1:0] rdata;
	logic we;
	entry_t wentry;
	logic pend_q;
	logic [255:0] pdata_q;
	logic stall;
	logic [SLOT_W-1:0] raddr;
	logic [SLOT_W-1:0] free_slot;
	logic any_free;

	kind_t kind;
	logic [31:0] c_saddr, c_daddr, c_now;
	logic [15:0] c_hints, c_mask;
	logic [175:0] c_name;
	logic c_all;
	assign kind = kind_t'(cmd_q[1:0]);
	assign c_saddr = cmd_q[33:2];
	assign c_daddr = cmd_q[65:34];
	assign c_hints = cmd_q[81:66];
	assign c_name = cmd_q[257:82];
	assign c_now = cmd_q[289:258];
	assign c_mask = cmd_q[305:290];
	assign c_all = cmd_q[306];

	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready = 1'b1;

	assign rd = entry_t'(rdata);
	assign wentry = '{saddr: c_saddr, daddr: c_daddr, hints: c_hints,
		name_lo: c_name[63:0], name_mid: c_name[127:64], name_hi: c_name[175:128],
		last_seen: c_now, first_seen: first_q};
	assign we = (state_q == DONE) && out_free && (kind == KIND_ADD) && have_free_q;
	assign raddr = stall ? cur_q : idx_q[SLOT_W-1:0];

	dct_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(free_q), .wdata(wentry),
		.raddr(raddr), .rdata(rdata)
	);

	logic v, hit_add, hit_exp, hit_q, hit;
	logic [31:0] age_l, age_f;
	always_comb begin
		v = valid_q[cur_q];
		age_l = c_now - rd.last_seen;
		age_f = c_now - rd.first_seen;
		hit_add = v && rd.saddr == c_saddr && (rd.daddr == c_daddr ||
			names_equal({rd.name_hi, rd.name_mid, rd.name_lo}, c_name));
		hit_exp = v && rd.saddr == c_saddr && (c_all || age_l > expire_q);
		hit_q = v && (rd.hints & c_mask) != 16'd0 && (c_all || age_f < window_q);
		hit = (kind == KIND_EXPIRE) ? hit_exp : (kind == KIND_QUERY) ? hit_q : 1'b0;
	end

	assign stall = (state_q == SCAN) && hit && pend_q && !out_free;

	// lowest free slot after removals, found by priority on valid bits
	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int s = ENTRIES - 1; s >= 0; s--) begin
			if (!valid_q[s]) begin
				any_free = 1'b1;
				free_slot = SLOT_W'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			expire_q <= 32'd600;
			window_q <= 32'd300;
			valid_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tlast <= 1'b0;
			m_axis_tuser <= '0;
			m_axis_tdata <= '0;
			pend_q <= 1'b0;
			n_q <= '0;
			have_free_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_EXPIRE) expire_q <= cfg_data;
				else window_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= s_axis_tdata[306:0];
						first_q <= s_axis_tdata[289:258];
						idx_q <= '0;
						n_q <= '0;
						pend_q <= 1'b0;
						have_free_q <= 1'b0;
						state_q <= READ;
					end
				end
				READ: begin
					cur_q <= idx_q[SLOT_W-1:0];
					idx_q <= idx_q + 1'b1;
					state_q <= SCAN;
				end
				SCAN: begin
					if (!stall) begin
						if (kind == KIND_ADD && hit_add) begin
							valid_q[cur_q] <= 1'b0;
							if (rd.hints == c_hints) first_q <= rd.first_seen;
						end
						if (hit) begin
							if (kind == KIND_EXPIRE) valid_q[cur_q] <= 1'b0;
							if (n_q < 5'd16) begin
								if (pend_q) begin
									m_axis_tvalid <= 1'b1;
									m_axis_tdata <= pdata_q;
									m_axis_tuser <= 2'b01;
									m_axis_tlast <= 1'b0;
								end
								pend_q <= 1'b1;
								pdata_q <= {rd.name_hi, rd.name_mid, rd.name_lo,
									rd.hints, rd.daddr, rd.saddr};
								n_q <= n_q + 1'b1;
							end
						end
						if (idx_q == (SLOT_W + 1)'(ENTRIES)) begin
							state_q <= WRITE;
						end else begin
							cur_q <= idx_q[SLOT_W-1:0];
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				WRITE: begin
					have_free_q <= any_free;
					free_q <= free_slot;
					state_q <= DONE;
				end
				DONE: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tlast <= 1'b1;
						if (pend_q) begin
							m_axis_tdata <= pdata_q;
							m_axis_tuser <= 2'b01;
						end else begin
							m_axis_tdata <= '0;
							m_axis_tuser <= {kind == KIND_ADD && !have_free_q, 1'b0};
						end
						if (we) valid_q[free_q] <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/dct_ram.sv =====
`default_nettype none
module dct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/dct_checker.sv =====
`default_nettype none
module dct_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic m_axis_tlast,
	input wire logic [1:0] m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("out dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("bad status");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast) else $error("empty not last");
endmodule
bind discovery_cache_table_core dct_checker u_chk (.*);
`default_nettype wire
